>>> rtl/core/tavpt_pkg.sv
// Shared types and constants for the three-axis velocity PID thrust block.
// No dependencies.
package tavpt_pkg;
  localparam int AxisCount = 3;
  localparam int ErrW = 17;
  localparam int DeltaW = 18;
  localparam int IntegW = 32;
  localparam int DriveW = 50;
  localparam int ScaledW = 67;
  localparam int CmdW = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgProp = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInteg = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeriv = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgScale = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_SCALE, ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [15:0] target_vel_x;
    logic signed [15:0] target_vel_y;
    logic signed [15:0] target_vel_z;
    logic signed [15:0] measured_vel_x;
    logic signed [15:0] measured_vel_y;
    logic signed [15:0] measured_vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] thrust_z_a;
    logic signed [15:0] thrust_z_b;
    logic signed [15:0] thrust_x_pos;
    logic signed [15:0] thrust_x_neg;
    logic signed [15:0] thrust_y_a;
    logic signed [15:0] thrust_y_b;
  } out_item_t;

  function automatic logic signed [CmdW-1:0] sat16(input logic signed [ScaledW-16:0] v);
    if (v > $signed(51'sd32767)) return 16'sh7fff;
    if (v < -$signed(51'sd32768)) return 16'sh8000;
    return v[CmdW-1:0];
  endfunction
endpackage

>>> rtl/core/tavpt_if.sv
// Valid/ready channel carrying one item.
// Depends on tavpt_pkg only for payload types given as parameter.
interface tavpt_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/three_axis_velocity_pid_thrust.sv
// Three-axis velocity PID controller driving six thruster commands.
// Depends on tavpt_pkg, tavpt_if and tavpt_serial_mul.
//
// Usage: write gains on cfg_* while idle. Offer an item of target and measured
// velocities on the in channel; one item of six saturated commands follows on
// the out channel. Each axis runs four multiplies on one bit-serial multiplier:
// prop, integ and deriv terms (serial over the 16 gain bits) and the output
// scale (serial over 17 bits, scale zero-extended). in_ready is high only when
// no item is in work and the output register is empty or being taken. A
// stalled receiver holds the result in the output register and the next item
// waits. Reset clears integrators and previous errors to zero and loads the
// register defaults. One item is in work at a time.
module three_axis_velocity_pid_thrust (
  input  logic clk,
  input  logic rst_n,
  tavpt_if.sink   in_ch,
  tavpt_if.source out_ch,
  input  logic cfg_we,
  input  logic [tavpt_pkg::CfgIdxW:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import tavpt_pkg::*;
  state_t st_r, st_nxt;
  logic signed [15:0] prop_r, integ_r, deriv_r;
  logic [15:0] scale_r;
  logic signed [IntegW-1:0] integ_sum_r [AxisCount];
  logic signed [ErrW-1:0] last_err_r [AxisCount];
  in_item_t item_r;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] term_r, term_nxt;
  logic signed [DriveW-1:0] drive_r;
  logic signed [ErrW-1:0] err_r;
  logic signed [ScaledW-1:0] scaled_r [AxisCount];
  out_item_t out_r;
  logic out_valid_r;
  logic signed [IntegW:0] isum;
  logic signed [IntegW-1:0] isat;
  logic signed [15:0] tgt, meas;
  logic mul_start, mul_busy;
  logic signed [DriveW-1:0] mcand, mplier;
  logic [5:0] nbits;
  logic signed [ScaledW-1:0] prod;
  logic signed [ScaledW-16:0] vz, vx, vy;
  logic signed [ScaledW-15:0] nvx;
  logic accept_in, out_take;

  assign out_take = out_valid_r && out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept_in = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (axis_r)
      2'd0: begin tgt = item_r.target_vel_x; meas = item_r.measured_vel_x; end
      2'd1: begin tgt = item_r.target_vel_y; meas = item_r.measured_vel_y; end
      default: begin tgt = item_r.target_vel_z; meas = item_r.measured_vel_z; end
    endcase
  end

  // integrator update for the axis in PREP
  always_comb begin
    isum = (IntegW+1)'(integ_sum_r[axis_r]) + (IntegW+1)'(tgt - meas);
    if (isum > $signed({2'b00, {(IntegW-1){1'b1}}})) isat = {1'b0, {(IntegW-1){1'b1}}};
    else if (isum < $signed({2'b11, {(IntegW-1){1'b0}}})) isat = {1'b1, {(IntegW-1){1'b0}}};
    else isat = isum[IntegW-1:0];
  end

  // operand select: gain is the serial multiplier operand
  always_comb begin
    mcand = '0; mplier = '0; nbits = 6'd16;
    if (st_r == ST_SCALE) begin
      mcand = drive_r; mplier = DriveW'($signed({1'b0, scale_r})); nbits = 6'd17;
    end else begin
      unique case (term_r)
        2'd0: begin mcand = DriveW'(err_r); mplier = DriveW'(prop_r); end
        2'd1: begin mcand = DriveW'(integ_sum_r[axis_r]); mplier = DriveW'(integ_r); end
        default: begin
          mcand = DriveW'(DeltaW'(err_r) - DeltaW'(last_err_r[axis_r]));
          mplier = DriveW'(deriv_r);
        end
      endcase
    end
  end

  tavpt_serial_mul u_mul (
    .clk, .rst_n, .start(mul_start), .mcand, .mplier, .nbits,
    .busy(mul_busy), .prod
  );

  // mul launches on entering MUL/SCALE and in the cycle after a finished term
  logic launch_r, launch_nxt;

  always_comb begin
    st_nxt = st_r; axis_nxt = axis_r; term_nxt = term_r; launch_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: if (accept_in) begin st_nxt = ST_PREP; axis_nxt = '0; end
      ST_PREP: begin st_nxt = ST_MUL; term_nxt = '0; launch_nxt = 1'b1; end
      ST_MUL: if (!launch_r && !mul_busy) begin
        if (term_r == 2'd2) begin st_nxt = ST_SCALE; launch_nxt = 1'b1; end
        else begin term_nxt = term_r + 2'd1; launch_nxt = 1'b1; end
      end
      ST_SCALE: if (!launch_r && !mul_busy) begin
        if (axis_r == 2'd2) st_nxt = ST_DONE;
        else begin axis_nxt = axis_r + 2'd1; st_nxt = ST_PREP; end
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = launch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; launch_r <= 1'b0; out_valid_r <= 1'b0;
      axis_r <= '0; term_r <= '0;
      prop_r <= 16'sd256; integ_r <= '0; deriv_r <= '0; scale_r <= 16'd256;
      for (int i = 0; i < AxisCount; i++) begin
        integ_sum_r[i] <= '0; last_err_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; launch_r <= launch_nxt; axis_r <= axis_nxt; term_r <= term_nxt;
      if (cfg_we) begin
        case (cfg_index)
          {1'b0, CfgProp}: prop_r <= cfg_data;
          {1'b0, CfgInteg}: integ_r <= cfg_data;
          {1'b0, CfgDeriv}: deriv_r <= cfg_data;
          {1'b0, CfgScale}: scale_r <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == ST_PREP) integ_sum_r[axis_r] <= isat;
      if (st_r == ST_SCALE && !launch_r && !mul_busy) last_err_r[axis_r] <= err_r;
      if (st_r == ST_DONE) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
    if (accept_in) item_r <= in_ch.data;
    if (st_r == ST_PREP) begin err_r <= ErrW'(tgt) - ErrW'(meas); drive_r <= '0; end
    if (st_r == ST_MUL && !launch_r && !mul_busy) drive_r <= drive_r + prod[DriveW-1:0];
    if (st_r == ST_SCALE && !launch_r && !mul_busy) scaled_r[axis_r] <= prod;
    if (st_r == ST_DONE) begin
      out_r.thrust_z_a <= sat16(vz); out_r.thrust_z_b <= sat16(vz);
      out_r.thrust_x_pos <= sat16(vx);
      out_r.thrust_x_neg <= (nvx > 52'sd32767) ? 16'sh7fff :
                            (nvx < -52'sd32768) ? 16'sh8000 : nvx[15:0];
      out_r.thrust_y_a <= sat16(vy); out_r.thrust_y_b <= sat16(vy);
    end
  end

  // arithmetic shift floors
  assign vx = (ScaledW-15)'(scaled_r[0] >>> 16);
  assign vy = (ScaledW-15)'(scaled_r[1] >>> 16);
  assign vz = (ScaledW-15)'(scaled_r[2] >>> 16);
  assign nvx = -(ScaledW-14)'(vx);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in |=> st_r == ST_PREP) else $error("accept did not start work");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && st_r != ST_DONE |=> $stable(out_r))
    else $error("result changed while stalled");
endmodule

>>> rtl/core/tavpt_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on tavpt_pkg.
module tavpt_serial_mul (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [tavpt_pkg::DriveW-1:0] mcand,
  input  logic signed [tavpt_pkg::DriveW-1:0] mplier,
  input  logic [5:0] nbits,
  output logic busy,
  output logic signed [tavpt_pkg::ScaledW-1:0] prod
);
  import tavpt_pkg::*;
  logic [5:0] cnt_r, cnt_nxt;
  logic signed [ScaledW-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic signed [DriveW-1:0] mp_r, mp_nxt;
  logic [5:0] last_r, last_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    cnt_nxt = cnt_r; acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r;
    busy_nxt = busy_r; last_nxt = last_r;
    if (start) begin
      acc_nxt = '0; mc_nxt = ScaledW'(mcand); mp_nxt = mplier;
      cnt_nxt = '0; busy_nxt = 1'b1; last_nxt = nbits - 6'd1;
    end else if (busy_r) begin
      // top multiplier bit has negative weight
      if (mp_r[0]) acc_nxt = (cnt_r == last_r) ? acc_r - mc_r : acc_r + mc_r;
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >>> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == last_r) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt; last_r <= last_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> cnt_r <= last_r) else $error("mul count past end");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("mul did not start");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == last_r |=> !busy_r) else $error("mul did not stop");
endmodule
